### rtl/rgbc_pkg.sv
`timescale 1ns / 1ps

package rgbc_pkg;

  // field widths
  localparam int CNT_W     = 16;
  localparam int CORR_W    = 19;
  localparam int IT_W      = 10;
  localparam int COEF_W    = 16;
  localparam int LEVEL_W   = 31;
  localparam int GAIN_W    = 2;
  localparam int CPL_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // serial arithmetic widths
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = 40;
  localparam int DIV_N_W = 36;
  localparam int DIV_D_W = 18;

  localparam int DEVICE_FACTOR_DEF = 310;

  localparam logic signed [MUL_B_W-1:0] LEVEL_SCALE = 17'sd1000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_COEF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_COEF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_COEF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CCT_COEF   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CCT_OFFSET = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_UP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DOWN  = 3'd7;

  // register reset values
  localparam logic [IT_W-1:0]          RST_INTEG_TIME = 10'd200;
  localparam logic signed [COEF_W-1:0] RST_RED_COEF   = 16'sd136;
  localparam logic signed [COEF_W-1:0] RST_GREEN_COEF = 16'sd1000;
  localparam logic signed [COEF_W-1:0] RST_BLUE_COEF  = -16'sd444;
  localparam logic signed [COEF_W-1:0] RST_CCT_COEF   = 16'sd3810;
  localparam logic signed [COEF_W-1:0] RST_CCT_OFFSET = 16'sd1391;
  localparam logic [CNT_W-1:0]         RST_GAIN_UP    = 16'd200;
  localparam logic [CNT_W-1:0]         RST_GAIN_DOWN  = 16'd65335;

  // gain codes
  localparam logic [GAIN_W-1:0] GAIN_1X  = 2'd0;
  localparam logic [GAIN_W-1:0] GAIN_4X  = 2'd1;
  localparam logic [GAIN_W-1:0] GAIN_16X = 2'd2;
  localparam logic [GAIN_W-1:0] GAIN_60X = 2'd3;

  typedef struct packed {
    logic start;
    logic accum;
  } mul_ctl_t;

  // analog gain factor of a gain code
  function automatic logic signed [MUL_B_W-1:0] gain_mult(input logic [GAIN_W-1:0] idx);
    logic signed [MUL_B_W-1:0] m;
    unique case (idx)
      GAIN_1X:  m = 17'sd1;
      GAIN_4X:  m = 17'sd4;
      GAIN_16X: m = 17'sd16;
      GAIN_60X: m = 17'sd60;
      default:  m = 17'sd1;
    endcase
    return m;
  endfunction

  // saturate an unsigned quotient to the level range
  function automatic logic [LEVEL_W-1:0] sat_level(input logic [DIV_N_W-1:0] q);
    logic [LEVEL_W-1:0] v;
    if (|q[DIV_N_W-1:LEVEL_W]) v = '1;
    else v = q[LEVEL_W-1:0];
    return v;
  endfunction

  // signed quotient plus offset, clamped to the level range
  function automatic logic [LEVEL_W-1:0] cct_level(input logic [DIV_N_W-1:0] q,
                                                   input logic neg,
                                                   input logic signed [COEF_W-1:0] ofs);
    logic signed [DIV_N_W+1:0] sq;
    logic signed [DIV_N_W+1:0] s;
    logic [LEVEL_W-1:0] v;
    sq = $signed({2'b00, q});
    if (neg) sq = -sq;
    s = sq + (DIV_N_W+2)'(ofs);
    if (s[DIV_N_W+1]) v = '0;
    else if (|s[DIV_N_W:LEVEL_W]) v = '1;
    else v = s[LEVEL_W-1:0];
    return v;
  endfunction

endpackage

### rtl/rgbc_ser_mul.sv
`timescale 1ns / 1ps

module rgbc_ser_mul #(
  parameter int A_W = rgbc_pkg::MUL_A_W,
  parameter int B_W = rgbc_pkg::MUL_B_W,
  parameter int P_W = rgbc_pkg::MUL_P_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rgbc_pkg::mul_ctl_t    ctl,
  input  logic signed [A_W-1:0] a,
  input  logic signed [B_W-1:0] b,
  output logic                  done,
  output logic signed [P_W-1:0] prod
);

  localparam int CW = $clog2(B_W);
  localparam logic [CW-1:0] LAST = CW'(B_W - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CW-1:0]         cnt_r;
  logic signed [P_W-1:0] a_sh_r;
  logic [B_W-1:0]        b_sh_r;
  logic signed [P_W-1:0] prod_r;
  logic                  last_w;

  assign last_w = (cnt_r == LAST);

  // bit counter, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_w) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift-add datapath, sign bit of b weighs negative
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_sh_r <= P_W'(a);
      b_sh_r <= b;
      if (!ctl.accum) prod_r <= '0;
    end else if (busy_r) begin
      if (b_sh_r[0]) prod_r <= last_w ? prod_r - a_sh_r : prod_r + a_sh_r;
      a_sh_r <= a_sh_r <<< 1;
      b_sh_r <= b_sh_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

### rtl/rgbc_ser_div.sv
`timescale 1ns / 1ps

module rgbc_ser_div #(
  parameter int N_W = rgbc_pkg::DIV_N_W,
  parameter int D_W = rgbc_pkg::DIV_D_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           done,
  output logic [N_W-1:0] quo
);

  localparam int CW = $clog2(N_W);
  localparam logic [CW-1:0] LAST = CW'(N_W - 1);

  logic           busy_r;
  logic           done_r;
  logic [CW-1:0]  cnt_r;
  logic [D_W-1:0] rem_r;
  logic [D_W-1:0] den_r;
  logic [N_W-1:0] quo_r;
  logic [D_W+1:0] trial_w;
  logic           borrow_w;

  // trial subtract of the divisor from the shifted remainder
  assign trial_w  = {1'b0, rem_r, quo_r[N_W-1]} - {2'b00, den_r};
  assign borrow_w = trial_w[D_W+1];

  // iteration counter, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      if (borrow_w) rem_r <= {rem_r[D_W-2:0], quo_r[N_W-1]};
      else rem_r <= trial_w[D_W-1:0];
      quo_r <= {quo_r[N_W-2:0], ~borrow_w};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### rtl/rgbc_lux_cct_autogain.sv
`timescale 1ns / 1ps

// channel   ports                                       direction
// in        in_valid, in_stall, in_*_count              request in
// out       out_valid, out_stall, out_* results         request out
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data   register write
//
// one request at a time; each takes nine products on the bit-serial
// multiplier and seven quotients on the restoring divider, in sequence
// synchronous active-low reset; no clearing pass, the block is ready at once
// a finished result waits in the output register while the next request is
// taken; a stalled output holds the sequencer only at its last step

module rgbc_lux_cct_autogain #(
  parameter int DEVICE_FACTOR = rgbc_pkg::DEVICE_FACTOR_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rgbc_pkg::CNT_W-1:0]          in_clear_count,
  input  logic [rgbc_pkg::CNT_W-1:0]          in_red_count,
  input  logic [rgbc_pkg::CNT_W-1:0]          in_green_count,
  input  logic [rgbc_pkg::CNT_W-1:0]          in_blue_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rgbc_pkg::LEVEL_W-1:0]        out_red_level,
  output logic [rgbc_pkg::LEVEL_W-1:0]        out_green_level,
  output logic [rgbc_pkg::LEVEL_W-1:0]        out_blue_level,
  output logic [rgbc_pkg::LEVEL_W-1:0]        out_clear_level,
  output logic [rgbc_pkg::LEVEL_W-1:0]        out_lux,
  output logic [rgbc_pkg::LEVEL_W-1:0]        out_color_temp,
  output logic [rgbc_pkg::GAIN_W-1:0]         out_gain_used,
  output logic [rgbc_pkg::GAIN_W-1:0]         out_gain_next,
  output logic                                out_math_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgbc_pkg::CFG_DAT_W-1:0]      cfg_data
);

  localparam int CNT_W   = rgbc_pkg::CNT_W;
  localparam int CORR_W  = rgbc_pkg::CORR_W;
  localparam int COEF_W  = rgbc_pkg::COEF_W;
  localparam int LEVEL_W = rgbc_pkg::LEVEL_W;
  localparam int GAIN_W  = rgbc_pkg::GAIN_W;
  localparam int CPL_W   = rgbc_pkg::CPL_W;
  localparam int A_W     = rgbc_pkg::MUL_A_W;
  localparam int B_W     = rgbc_pkg::MUL_B_W;
  localparam int P_W     = rgbc_pkg::MUL_P_W;
  localparam int N_W     = rgbc_pkg::DIV_N_W;
  localparam int D_W     = rgbc_pkg::DIV_D_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // computation steps, each one product (three for lux) and a quotient
  localparam logic [2:0] STEP_CPL   = 3'd0;
  localparam logic [2:0] STEP_CCT   = 3'd1;
  localparam logic [2:0] STEP_LUX   = 3'd2;
  localparam logic [2:0] STEP_RED   = 3'd3;
  localparam logic [2:0] STEP_GREEN = 3'd4;
  localparam logic [2:0] STEP_BLUE  = 3'd5;
  localparam logic [2:0] STEP_CLEAR = 3'd6;

  localparam logic [1:0] LUX_TERM_LAST = 2'd2;

  // configuration registers
  logic [rgbc_pkg::IT_W-1:0] it_r;
  logic signed [COEF_W-1:0]  red_coef_r;
  logic signed [COEF_W-1:0]  green_coef_r;
  logic signed [COEF_W-1:0]  blue_coef_r;
  logic signed [COEF_W-1:0]  cct_coef_r;
  logic signed [COEF_W-1:0]  cct_offset_r;
  logic [CNT_W-1:0]          gain_up_r;
  logic [CNT_W-1:0]          gain_down_r;

  // sequencer and item state
  logic [2:0]               state_r;
  logic [2:0]               step_r;
  logic [1:0]               term_r;
  logic                     mul_go_r;
  logic                     div_go_r;
  logic [GAIN_W-1:0]        gain_idx_r;
  logic [GAIN_W-1:0]        gain_used_r;
  logic [GAIN_W-1:0]        gain_next_r;
  logic [GAIN_W-1:0]        gain_next_w;
  logic [CNT_W-1:0]         c_raw_r;
  logic [CNT_W-1:0]         r_raw_r;
  logic [CNT_W-1:0]         g_raw_r;
  logic [CNT_W-1:0]         b_raw_r;
  logic signed [CORR_W-1:0] r_cor_r;
  logic signed [CORR_W-1:0] g_cor_r;
  logic signed [CORR_W-1:0] b_cor_r;
  logic [CPL_W-1:0]         cpl_r;
  logic [LEVEL_W-1:0]       ct_r;
  logic [LEVEL_W-1:0]       lux_r;
  logic [LEVEL_W-1:0]       rl_r;
  logic [LEVEL_W-1:0]       gl_r;
  logic [LEVEL_W-1:0]       bl_r;

  // output register
  logic                out_valid_r;
  logic [LEVEL_W-1:0]  out_rl_r;
  logic [LEVEL_W-1:0]  out_gl_r;
  logic [LEVEL_W-1:0]  out_bl_r;
  logic [LEVEL_W-1:0]  out_cl_r;
  logic [LEVEL_W-1:0]  out_lux_r;
  logic [LEVEL_W-1:0]  out_ct_r;
  logic [GAIN_W-1:0]   out_used_r;
  logic [GAIN_W-1:0]   out_next_r;
  logic                out_err_r;

  // arithmetic unit hookup
  rgbc_pkg::mul_ctl_t    mul_ctl;
  logic signed [A_W-1:0] mul_a;
  logic signed [B_W-1:0] mul_b;
  logic                  mul_done;
  logic signed [P_W-1:0] mul_prod;
  logic [N_W-1:0]        div_num;
  logic [D_W-1:0]        div_den;
  logic                  div_done;
  logic [N_W-1:0]        div_quo;

  logic signed [CORR_W-1:0] sum_w;
  logic signed [CORR_W-1:0] ir_w;
  logic signed [P_W-1:0]    prod_abs_w;
  logic signed [CORR_W-1:0] r_abs_w;
  logic                     cct_neg_w;
  logic                     take_out_w;

  // nothing is taken while reset is held
  assign cfg_ready = rst_n;
  assign in_stall  = !rst_n || (state_r != S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_r         <= rgbc_pkg::RST_INTEG_TIME;
      red_coef_r   <= rgbc_pkg::RST_RED_COEF;
      green_coef_r <= rgbc_pkg::RST_GREEN_COEF;
      blue_coef_r  <= rgbc_pkg::RST_BLUE_COEF;
      cct_coef_r   <= rgbc_pkg::RST_CCT_COEF;
      cct_offset_r <= rgbc_pkg::RST_CCT_OFFSET;
      gain_up_r    <= rgbc_pkg::RST_GAIN_UP;
      gain_down_r  <= rgbc_pkg::RST_GAIN_DOWN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rgbc_pkg::REG_INTEG_TIME: it_r         <= cfg_data[rgbc_pkg::IT_W-1:0];
        rgbc_pkg::REG_RED_COEF:   red_coef_r   <= cfg_data;
        rgbc_pkg::REG_GREEN_COEF: green_coef_r <= cfg_data;
        rgbc_pkg::REG_BLUE_COEF:  blue_coef_r  <= cfg_data;
        rgbc_pkg::REG_CCT_COEF:   cct_coef_r   <= cfg_data;
        rgbc_pkg::REG_CCT_OFFSET: cct_offset_r <= cfg_data;
        rgbc_pkg::REG_GAIN_UP:    gain_up_r    <= cfg_data;
        rgbc_pkg::REG_GAIN_DOWN:  gain_down_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ir estimate, half of r+g+b-c rounded toward minus infinity
  assign sum_w = $signed({3'b000, r_raw_r}) + $signed({3'b000, g_raw_r})
               + $signed({3'b000, b_raw_r}) - $signed({3'b000, c_raw_r});
  assign ir_w  = sum_w >>> 1;

  // autogain step from the raw clear count
  always_comb begin
    gain_next_w = gain_used_r;
    if (c_raw_r < gain_up_r) begin
      if (gain_used_r != rgbc_pkg::GAIN_60X) gain_next_w = gain_used_r + 1'b1;
    end else if (c_raw_r > gain_down_r) begin
      if (gain_used_r != rgbc_pkg::GAIN_1X) gain_next_w = gain_used_r - 1'b1;
    end
  end

  // multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = rgbc_pkg::LEVEL_SCALE;
    case (step_r)
      STEP_CPL: begin
        mul_a = A_W'(it_r);
        mul_b = rgbc_pkg::gain_mult(gain_used_r);
      end
      STEP_CCT: begin
        mul_a = A_W'(b_cor_r);
        mul_b = B_W'(cct_coef_r);
      end
      STEP_LUX: begin
        case (term_r)
          2'd0: begin
            mul_a = A_W'(r_cor_r);
            mul_b = B_W'(red_coef_r);
          end
          2'd1: begin
            mul_a = A_W'(g_cor_r);
            mul_b = B_W'(green_coef_r);
          end
          default: begin
            mul_a = A_W'(b_cor_r);
            mul_b = B_W'(blue_coef_r);
          end
        endcase
      end
      STEP_RED:   mul_a = r_cor_r[CORR_W-1] ? '0 : A_W'(r_cor_r);
      STEP_GREEN: mul_a = g_cor_r[CORR_W-1] ? '0 : A_W'(g_cor_r);
      STEP_BLUE:  mul_a = b_cor_r[CORR_W-1] ? '0 : A_W'(b_cor_r);
      default:    mul_a = A_W'(c_raw_r);
    endcase
  end

  assign mul_ctl.start = mul_go_r;
  assign mul_ctl.accum = (step_r == STEP_LUX) && (term_r != 2'd0);

  // divider operands per step
  assign prod_abs_w = mul_prod[P_W-1] ? -mul_prod : mul_prod;
  assign r_abs_w    = r_cor_r[CORR_W-1] ? -r_cor_r : r_cor_r;
  assign cct_neg_w  = mul_prod[P_W-1] ^ r_cor_r[CORR_W-1];

  always_comb begin
    div_num = mul_prod[N_W-1:0];
    div_den = D_W'(cpl_r);
    case (step_r)
      STEP_CPL: div_den = D_W'(DEVICE_FACTOR);
      STEP_CCT: begin
        div_num = prod_abs_w[N_W-1:0];
        div_den = r_abs_w[D_W-1:0];
      end
      STEP_LUX: div_num = mul_prod[P_W-1] ? '0 : mul_prod[N_W-1:0];
      default: ;
    endcase
  end

  rgbc_ser_mul #(
    .A_W (A_W),
    .B_W (B_W),
    .P_W (P_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  rgbc_ser_div #(
    .N_W (N_W),
    .D_W (D_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign take_out_w = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_CPL;
      term_r      <= 2'd0;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      gain_idx_r  <= rgbc_pkg::GAIN_4X;
      out_valid_r <= 1'b0;
    end else begin
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      if (take_out_w) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_PREP;
        end
        S_PREP: begin
          step_r   <= STEP_CPL;
          term_r   <= 2'd0;
          mul_go_r <= 1'b1;
          state_r  <= S_MUL;
        end
        S_MUL: begin
          if (mul_done) begin
            if ((step_r == STEP_LUX) && (term_r != LUX_TERM_LAST)) begin
              term_r   <= term_r + 1'b1;
              mul_go_r <= 1'b1;
            end else begin
              div_go_r <= 1'b1;
              state_r  <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (step_r == STEP_CLEAR) begin
              state_r <= S_DONE;
            end else begin
              step_r   <= step_r + 1'b1;
              term_r   <= 2'd0;
              mul_go_r <= 1'b1;
              state_r  <= S_MUL;
            end
          end
        end
        S_DONE: begin
          if (take_out_w) begin
            gain_idx_r <= gain_next_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // item capture and corrected channels
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      c_raw_r     <= in_clear_count;
      r_raw_r     <= in_red_count;
      g_raw_r     <= in_green_count;
      b_raw_r     <= in_blue_count;
      gain_used_r <= gain_idx_r;
    end
    if (state_r == S_PREP) begin
      r_cor_r     <= $signed({3'b000, r_raw_r}) - ir_w;
      g_cor_r     <= $signed({3'b000, g_raw_r}) - ir_w;
      b_cor_r     <= $signed({3'b000, b_raw_r}) - ir_w;
      gain_next_r <= gain_next_w;
    end
  end

  // quotient results per step
  always_ff @(posedge clk) begin
    if ((state_r == S_DIV) && div_done) begin
      case (step_r)
        STEP_CPL: cpl_r <= div_quo[CPL_W-1:0];
        STEP_CCT: begin
          if (r_cor_r == '0) ct_r <= '0;
          else ct_r <= rgbc_pkg::cct_level(div_quo, cct_neg_w, cct_offset_r);
        end
        STEP_LUX:   lux_r <= (cpl_r == '0) ? '0 : rgbc_pkg::sat_level(div_quo);
        STEP_RED:   rl_r  <= (cpl_r == '0) ? '0 : rgbc_pkg::sat_level(div_quo);
        STEP_GREEN: gl_r  <= (cpl_r == '0) ? '0 : rgbc_pkg::sat_level(div_quo);
        STEP_BLUE:  bl_r  <= (cpl_r == '0) ? '0 : rgbc_pkg::sat_level(div_quo);
        default: ;
      endcase
    end
  end

  // result register load
  always_ff @(posedge clk) begin
    if (take_out_w) begin
      out_rl_r   <= rl_r;
      out_gl_r   <= gl_r;
      out_bl_r   <= bl_r;
      out_cl_r   <= (cpl_r == '0) ? '0 : rgbc_pkg::sat_level(div_quo);
      out_lux_r  <= lux_r;
      out_ct_r   <= ct_r;
      out_used_r <= gain_used_r;
      out_next_r <= gain_next_r;
      out_err_r  <= (r_cor_r == '0) || (cpl_r == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = out_rl_r;
  assign out_green_level = out_gl_r;
  assign out_blue_level  = out_bl_r;
  assign out_clear_level = out_cl_r;
  assign out_lux         = out_lux_r;
  assign out_color_temp  = out_ct_r;
  assign out_gain_used   = out_used_r;
  assign out_gain_next   = out_next_r;
  assign out_math_error  = out_err_r;

endmodule

### sim/rgbc_lux_cct_autogain_tb.sv
`timescale 1ns / 1ps

module rgbc_lux_cct_autogain_tb;
  import rgbc_pkg::*;

  localparam int DEV_FACTOR      = DEVICE_FACTOR_DEF;
  localparam int STALL_LIMIT     = 20000;
  localparam int DRAIN_CYCLES    = 1000;
  localparam int REPORT_MAX      = 10;
  localparam int BATCHES_PER_MODE = 5;
  localparam int BATCH_LEN       = 100;
  localparam longint LEVEL_TOP   = 64'd2147483647;

  typedef enum logic [1:0] {JOB_SAMPLE, JOB_REG_WRITE, JOB_PACING} job_kind_t;

  // one light reading as the block reports it
  typedef struct packed {
    logic [LEVEL_W-1:0] red_lvl;
    logic [LEVEL_W-1:0] green_lvl;
    logic [LEVEL_W-1:0] blue_lvl;
    logic [LEVEL_W-1:0] clear_lvl;
    logic [LEVEL_W-1:0] lux;
    logic [LEVEL_W-1:0] color_temp;
    logic [GAIN_W-1:0]  gain_used;
    logic [GAIN_W-1:0]  gain_next;
    logic               math_err;
  } reading_t;

  // sensor sample, register write or change of pacing
  typedef struct {
    job_kind_t            kind;
    logic [CNT_W-1:0]     clear_cnt;
    logic [CNT_W-1:0]     red_cnt;
    logic [CNT_W-1:0]     green_cnt;
    logic [CNT_W-1:0]     blue_cnt;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_val;
    int                   send_gap_pct;
    int                   recv_stall_pct;
  } job_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CNT_W-1:0]     in_clear_count = '0;
  logic [CNT_W-1:0]     in_red_count = '0;
  logic [CNT_W-1:0]     in_green_count = '0;
  logic [CNT_W-1:0]     in_blue_count = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [LEVEL_W-1:0]   out_red_level;
  logic [LEVEL_W-1:0]   out_green_level;
  logic [LEVEL_W-1:0]   out_blue_level;
  logic [LEVEL_W-1:0]   out_clear_level;
  logic [LEVEL_W-1:0]   out_lux;
  logic [LEVEL_W-1:0]   out_color_temp;
  logic [GAIN_W-1:0]    out_gain_used;
  logic [GAIN_W-1:0]    out_gain_next;
  logic                 out_math_error;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // predictor copy of the registers and the gain state
  logic [IT_W-1:0]          integ_time = RST_INTEG_TIME;
  logic signed [COEF_W-1:0] red_coef = RST_RED_COEF;
  logic signed [COEF_W-1:0] green_coef = RST_GREEN_COEF;
  logic signed [COEF_W-1:0] blue_coef = RST_BLUE_COEF;
  logic signed [COEF_W-1:0] cct_coef = RST_CCT_COEF;
  logic signed [COEF_W-1:0] cct_offset = RST_CCT_OFFSET;
  logic [CNT_W-1:0]         gain_up_thr = RST_GAIN_UP;
  logic [CNT_W-1:0]         gain_down_thr = RST_GAIN_DOWN;
  logic [GAIN_W-1:0]        gain_state = GAIN_4X;

  job_t     jobs[$];
  reading_t readings_due[$];
  int       send_gap_pct = 0;
  int       recv_stall_pct = 0;
  int       fault_cnt = 0;
  int       idle_cycles = 0;
  int       plan_up_thr = RST_GAIN_UP;
  int       plan_down_thr = RST_GAIN_DOWN;

  rgbc_lux_cct_autogain #(
    .DEVICE_FACTOR(DEV_FACTOR)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_clear_count  (in_clear_count),
    .in_red_count    (in_red_count),
    .in_green_count  (in_green_count),
    .in_blue_count   (in_blue_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_clear_level (out_clear_level),
    .out_lux         (out_lux),
    .out_color_temp  (out_color_temp),
    .out_gain_used   (out_gain_used),
    .out_gain_next   (out_gain_next),
    .out_math_error  (out_math_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic [LEVEL_W-1:0] clamp_level(input longint v);
    if (v < 0) return '0;
    if (v > LEVEL_TOP) return '1;
    return v[LEVEL_W-1:0];
  endfunction

  // corrected channel scaled by 1000 over counts per lux
  function automatic logic [LEVEL_W-1:0] channel_level(input longint v, input longint cpl);
    if (v < 0 || cpl <= 0) return '0;
    return clamp_level(v * 1000 / cpl);
  endfunction

  function automatic longint gain_factor(input logic [GAIN_W-1:0] g);
    case (g)
      GAIN_1X:  return 1;
      GAIN_4X:  return 4;
      GAIN_16X: return 16;
      default:  return 60;
    endcase
  endfunction

  // expected reading for one request, advances the autogain state
  task automatic predict_reading(input logic [CNT_W-1:0] cc, input logic [CNT_W-1:0] rc,
                                 input logic [CNT_W-1:0] gc, input logic [CNT_W-1:0] bc);
    reading_t exp_rd;
    longint c, r, g, b, ir, cpl, wsum;
    c = longint'(cc);
    r = longint'(rc);
    g = longint'(gc);
    b = longint'(bc);
    // remove the ir share, floor of half the excess
    ir = (r + g + b - c) >>> 1;
    r = r - ir;
    g = g - ir;
    b = b - ir;
    exp_rd.gain_used = gain_state;
    exp_rd.gain_next = gain_state;
    exp_rd.math_err = 1'b0;
    if (r == 0) begin
      exp_rd.math_err = 1'b1;
      exp_rd.color_temp = '0;
    end else begin
      exp_rd.color_temp = clamp_level(longint'(cct_coef) * b / r + longint'(cct_offset));
    end
    cpl = longint'(integ_time) * gain_factor(gain_state) / DEV_FACTOR;
    wsum = longint'(red_coef) * r + longint'(green_coef) * g + longint'(blue_coef) * b;
    if (cpl <= 0) begin
      exp_rd.math_err = 1'b1;
      exp_rd.lux = '0;
    end else begin
      exp_rd.lux = clamp_level(wsum / cpl);
    end
    exp_rd.red_lvl = channel_level(r, cpl);
    exp_rd.green_lvl = channel_level(g, cpl);
    exp_rd.blue_lvl = channel_level(b, cpl);
    exp_rd.clear_lvl = channel_level(c, cpl);
    // autogain, raise test wins when thresholds overlap
    if (cc < gain_up_thr) begin
      if (gain_state != GAIN_60X) exp_rd.gain_next = gain_state + 1'b1;
    end else if (cc > gain_down_thr) begin
      if (gain_state != GAIN_1X) exp_rd.gain_next = gain_state - 1'b1;
    end
    gain_state = exp_rd.gain_next;
    readings_due.push_back(exp_rd);
  endtask

  task automatic check_field(input string fname, input logic [LEVEL_W-1:0] want,
                             input logic [LEVEL_W-1:0] got);
    if (want !== got) begin
      fault_cnt++;
      if (fault_cnt <= REPORT_MAX)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  task automatic add_sample(input int cv, input int rv, input int gv, input int bv);
    job_t job;
    job.kind = JOB_SAMPLE;
    job.clear_cnt = CNT_W'(cv);
    job.red_cnt = CNT_W'(rv);
    job.green_cnt = CNT_W'(gv);
    job.blue_cnt = CNT_W'(bv);
    jobs.push_back(job);
  endtask

  task automatic add_reg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
    job_t job;
    job.kind = JOB_REG_WRITE;
    job.reg_idx = idx;
    job.reg_val = CFG_DAT_W'(val);
    if (idx == REG_GAIN_UP) plan_up_thr = val;
    if (idx == REG_GAIN_DOWN) plan_down_thr = val;
    jobs.push_back(job);
  endtask

  task automatic add_pacing(input int send_pct, input int recv_pct);
    job_t job;
    job.kind = JOB_PACING;
    job.send_gap_pct = send_pct;
    job.recv_stall_pct = recv_pct;
    jobs.push_back(job);
  endtask

  // driver: requests and register writes from the job queue
  always @(posedge clk) begin
    logic nxt_in;
    logic nxt_cfg;
    job_t job;
    nxt_in = in_valid;
    nxt_cfg = cfg_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_reading(in_clear_count, in_red_count, in_green_count, in_blue_count);
        nxt_in = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INTEG_TIME: integ_time = cfg_data[IT_W-1:0];
          REG_RED_COEF:   red_coef = cfg_data;
          REG_GREEN_COEF: green_coef = cfg_data;
          REG_BLUE_COEF:  blue_coef = cfg_data;
          REG_CCT_COEF:   cct_coef = cfg_data;
          REG_CCT_OFFSET: cct_offset = cfg_data;
          REG_GAIN_UP:    gain_up_thr = cfg_data;
          REG_GAIN_DOWN:  gain_down_thr = cfg_data;
          default: ;
        endcase
        nxt_cfg = 1'b0;
      end
      if (!nxt_in && !nxt_cfg && jobs.size() != 0) begin
        job = jobs[0];
        case (job.kind)
          JOB_PACING: begin
            send_gap_pct = job.send_gap_pct;
            recv_stall_pct = job.recv_stall_pct;
            void'(jobs.pop_front());
          end
          // register writes only once every reading is back
          JOB_REG_WRITE: begin
            if (readings_due.size() == 0) begin
              cfg_index <= job.reg_idx;
              cfg_data <= job.reg_val;
              nxt_cfg = 1'b1;
              void'(jobs.pop_front());
            end
          end
          default: begin
            if ($urandom_range(99) >= send_gap_pct) begin
              in_clear_count <= job.clear_cnt;
              in_red_count <= job.red_cnt;
              in_green_count <= job.green_cnt;
              in_blue_count <= job.blue_cnt;
              nxt_in = 1'b1;
              void'(jobs.pop_front());
            end
          end
        endcase
      end
    end
    in_valid <= nxt_in;
    cfg_valid <= nxt_cfg;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: compare each accepted reading with the oldest prediction
  always @(posedge clk) begin
    reading_t exp_rd;
    if (rst_n && out_valid && !out_stall) begin
      if (readings_due.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= REPORT_MAX)
          $display("%0t: reading with no request outstanding", $time);
      end else begin
        exp_rd = readings_due.pop_front();
        check_field("red_level", exp_rd.red_lvl, out_red_level);
        check_field("green_level", exp_rd.green_lvl, out_green_level);
        check_field("blue_level", exp_rd.blue_lvl, out_blue_level);
        check_field("clear_level", exp_rd.clear_lvl, out_clear_level);
        check_field("lux", exp_rd.lux, out_lux);
        check_field("color_temp", exp_rd.color_temp, out_color_temp);
        check_field("gain_used", LEVEL_W'(exp_rd.gain_used), LEVEL_W'(out_gain_used));
        check_field("gain_next", LEVEL_W'(exp_rd.gain_next), LEVEL_W'(out_gain_next));
        check_field("math_error", LEVEL_W'(exp_rd.math_err), LEVEL_W'(out_math_error));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("rgbc_lux_cct_autogain regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus plan and end of run
  initial begin
    int sel;
    int cv, rv, gv, bv;
    int val;
    logic [CFG_IDX_W-1:0] idx;

    add_pacing(16, 52);

    // gain walks up from 4x, saturates at 60x, then back down to 1x
    add_sample(0, 0, 0, 0);
    add_sample(0, 65535, 65535, 65535);
    add_sample(100, 65535, 65535, 65535);
    add_sample(200, 200, 200, 200);
    add_sample(65335, 1000, 2000, 3000);
    add_sample(65535, 0, 0, 0);
    add_sample(65535, 65535, 65535, 65535);
    add_sample(65400, 12345, 23456, 34567);
    // 1x at the reset time gives zero counts per lux
    add_sample(65535, 1, 2, 3);
    add_sample(50000, 40000, 30000, 20000);
    add_sample(0, 65535, 0, 0);
    // corrected red of zero
    add_sample(1000, 1000, 1000, 1000);
    add_sample(1, 0, 0, 65535);
    add_sample(32768, 32767, 32767, 32767);
    add_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    add_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);

    // upper extremes, gain held
    add_reg_write(REG_INTEG_TIME, 1023);
    add_reg_write(REG_RED_COEF, 32767);
    add_reg_write(REG_GREEN_COEF, 32767);
    add_reg_write(REG_BLUE_COEF, 32767);
    add_reg_write(REG_CCT_COEF, -32768);
    add_reg_write(REG_CCT_OFFSET, 32767);
    add_reg_write(REG_GAIN_UP, 0);
    add_reg_write(REG_GAIN_DOWN, 65535);
    add_sample(65535, 0, 0, 0);
    add_sample(0, 2, 0, 0);
    add_sample(65535, 0, 0, 65533);

    // lower extremes, overlapping thresholds
    add_reg_write(REG_INTEG_TIME, 1);
    add_reg_write(REG_RED_COEF, -32768);
    add_reg_write(REG_GREEN_COEF, -32768);
    add_reg_write(REG_BLUE_COEF, -32768);
    add_reg_write(REG_CCT_COEF, 32767);
    add_reg_write(REG_CCT_OFFSET, -32768);
    add_reg_write(REG_GAIN_UP, 65535);
    add_reg_write(REG_GAIN_DOWN, 0);
    add_sample(65535, 0, 0, 0);
    add_sample(65534, 100, 200, 300);
    add_sample(0, 65535, 65535, 65535);

    // random batches, settings changed between them
    for (int mode = 0; mode < 3; mode++) begin
      if (mode == 1) add_pacing(52, 16);
      else if (mode == 2) add_pacing(0, 0);
      for (int batch = 0; batch < BATCHES_PER_MODE; batch++) begin
        for (int ri = REG_INTEG_TIME; ri <= REG_GAIN_DOWN; ri++) begin
          if ((mode == 0 && batch == 0) || $urandom_range(1) == 1) begin
            idx = CFG_IDX_W'(ri);
            case (idx)
              REG_INTEG_TIME: begin
                sel = $urandom_range(3);
                val = (sel == 0) ? 1 : (sel == 1) ? 1023 : $urandom_range(1023, 1);
              end
              REG_GAIN_UP: begin
                sel = $urandom_range(4);
                val = (sel == 0) ? 0 : (sel == 1) ? 65535 : $urandom_range(3000);
              end
              REG_GAIN_DOWN: begin
                sel = $urandom_range(4);
                val = (sel == 0) ? 65535 : (sel == 1) ? 0 : 65535 - $urandom_range(3000);
              end
              default: begin
                sel = $urandom_range(4);
                val = (sel == 0) ? -32768 : (sel == 1) ? 32767 :
                      (sel == 2) ? 0 : $urandom_range(65535);
              end
            endcase
            add_reg_write(idx, val);
          end
        end
        for (int k = 0; k < BATCH_LEN; k++) begin
          sel = $urandom_range(9);
          cv = $urandom_range(65535);
          rv = $urandom_range(65535);
          gv = $urandom_range(65535);
          bv = $urandom_range(65535);
          case (sel)
            // dim scene
            5: begin
              cv = $urandom_range(800);
              rv = $urandom_range(3000);
              gv = $urandom_range(3000);
              bv = $urandom_range(3000);
            end
            // bright scene
            6: cv = 65535 - $urandom_range(800);
            // all channels equal, corrected red of zero
            7: begin
              rv = cv;
              gv = cv;
              bv = cv;
            end
            // clear right at a threshold
            8: begin
              cv = ($urandom_range(1) ? plan_up_thr : plan_down_thr) + $urandom_range(4) - 2;
              if (cv < 0) cv = 0;
              if (cv > 65535) cv = 65535;
            end
            9: begin
              cv = $urandom_range(1) ? 65535 : 0;
              rv = $urandom_range(1) ? 65535 : 0;
              gv = $urandom_range(1) ? 65535 : 0;
              bv = $urandom_range(1) ? 65535 : 0;
            end
            default: ;
          endcase
          add_sample(cv, rv, gv, bv);
        end
      end
    end

    while (!rst_n) @(posedge clk);
    while (jobs.size() != 0 || in_valid || cfg_valid) @(posedge clk);
    while (readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("rgbc_lux_cct_autogain regression: pass");
    end else begin
      $display("rgbc_lux_cct_autogain regression: fail");
    end
    $finish;
  end

endmodule
